FILE: rtl/uart_ring_buffer_pair_unit_defines.svh
// ----------------------------------------------------------------------------
// uart ring buffer pair assertion macros
// shared concurrent assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef UART_RING_BUFFER_PAIR_UNIT_DEFINES_SVH
`define UART_RING_BUFFER_PAIR_UNIT_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define URBP_ASSERT_SAME(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("urbp same-cycle check failed");

// condition holds in the cycle after the trigger
`define URBP_ASSERT_NEXT(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("urbp next-cycle check failed");

`endif

FILE: rtl/urbp_pkg.sv
// ----------------------------------------------------------------------------
// urbp_pkg
// action codes and field widths for the uart ring buffer pair
// ----------------------------------------------------------------------------
package urbp_pkg;

    localparam int ACT_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int ERR_W   = 3;
    localparam int COUNT_W = 6;

    localparam logic [ACT_W-1:0] ACT_POP_RX   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH_TX  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_FLUSH_RX = 3'd2;
    localparam logic [ACT_W-1:0] ACT_FLUSH_TX = 3'd3;
    localparam logic [ACT_W-1:0] ACT_LINE     = 3'd4;

    typedef logic [BYTE_W-1:0] t_byte;

endpackage

FILE: rtl/uart_ring_buffer_pair_unit.sv
// ----------------------------------------------------------------------------
// uart_ring_buffer_pair_unit
// receive and transmit byte ring buffers between a host and a uart line
// ----------------------------------------------------------------------------
// Usage:
//   An item (host pop, host push, flush of either buffer, or a line event) is
//   taken at a rising edge with start high and busy low. busy is always low,
//   so one item can be taken every clock cycle.
//   Exactly one result follows each item: o_done is high for one cycle, the
//   cycle after the item is taken, with read/send bytes, drop and error flags,
//   the transmitter enable and both occupancy counts after the item.
//   Throughput is one item per cycle; each result is registered, and the
//   registered read port of each byte store is read at the same edge that
//   takes the item and updates the head and tail pointers.
//   Each buffer holds at most its depth minus one bytes; a push into a full
//   buffer is dropped and flagged.
//   Reset clears all pointers, switches the transmitter off and clears o_done;
//   store contents are not cleared and are only read once written.
//   The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module uart_ring_buffer_pair_unit #(
    parameter int RX_DEPTH = 64,
    parameter int TX_DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [urbp_pkg::ACT_W-1:0]    i_action,
    input  logic [urbp_pkg::BYTE_W-1:0]   i_host_byte,
    input  logic                          i_line_rx_full,
    input  logic [urbp_pkg::BYTE_W-1:0]   i_line_rx_byte,
    input  logic [urbp_pkg::ERR_W-1:0]    i_line_errors,
    input  logic                          i_line_tx_empty,
    output logic                          o_done,
    output logic [urbp_pkg::BYTE_W-1:0]   o_read_byte,
    output logic                          o_read_valid,
    output logic [urbp_pkg::BYTE_W-1:0]   o_send_byte,
    output logic                          o_send_valid,
    output logic                          o_transmitter_on,
    output logic [urbp_pkg::COUNT_W-1:0]  o_rx_count,
    output logic [urbp_pkg::COUNT_W-1:0]  o_tx_count,
    output logic                          o_error_seen,
    output logic                          o_rx_dropped,
    output logic                          o_tx_dropped
);
    import urbp_pkg::*;

    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam int RX_CW = RX_AW + 1;
    localparam int TX_CW = TX_AW + 1;

    typedef logic [RX_AW-1:0] t_rx_ptr;
    typedef logic [TX_AW-1:0] t_tx_ptr;

    t_byte   rx_mem [RX_DEPTH];
    t_byte   tx_mem [TX_DEPTH];

    t_rx_ptr r_rx_head, n_rx_head, r_rx_tail, n_rx_tail;
    t_tx_ptr r_tx_head, n_tx_head, r_tx_tail, n_tx_tail;
    logic    r_tx_active, n_tx_active;

    t_byte   r_rx_q, r_tx_q;
    logic    r_done;
    logic    r_read_valid, n_read_valid;
    logic    r_send_valid, n_send_valid;
    logic    r_error_seen, n_error_seen;
    logic    r_rx_dropped, n_rx_dropped;
    logic    r_tx_dropped, n_tx_dropped;
    logic    rx_we, tx_we;
    logic    accept;

    logic [COUNT_W-1:0] r_rx_count, r_tx_count;
    logic [RX_CW-1:0]   rx_cnt;
    logic [TX_CW-1:0]   tx_cnt;
    t_rx_ptr            rx_tail_inc;
    t_tx_ptr            tx_tail_inc;
    t_rx_ptr            rx_head_inc;
    t_tx_ptr            tx_head_inc;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // ring increments
    assign rx_tail_inc = (r_rx_tail == RX_AW'(RX_DEPTH - 1)) ? '0 : r_rx_tail + 1'b1;
    assign rx_head_inc = (r_rx_head == RX_AW'(RX_DEPTH - 1)) ? '0 : r_rx_head + 1'b1;
    assign tx_tail_inc = (r_tx_tail == TX_AW'(TX_DEPTH - 1)) ? '0 : r_tx_tail + 1'b1;
    assign tx_head_inc = (r_tx_head == TX_AW'(TX_DEPTH - 1)) ? '0 : r_tx_head + 1'b1;

    always_comb begin
        n_rx_head    = r_rx_head;
        n_rx_tail    = r_rx_tail;
        n_tx_head    = r_tx_head;
        n_tx_tail    = r_tx_tail;
        n_tx_active  = r_tx_active;
        n_read_valid = 1'b0;
        n_send_valid = 1'b0;
        n_error_seen = 1'b0;
        n_rx_dropped = 1'b0;
        n_tx_dropped = 1'b0;
        rx_we        = 1'b0;
        tx_we        = 1'b0;
        if (accept) begin
            case (i_action)
                ACT_POP_RX: begin
                    if (r_rx_head != r_rx_tail) begin
                        n_read_valid = 1'b1;
                        n_rx_head    = rx_head_inc;
                    end
                end
                ACT_PUSH_TX: begin
                    if (tx_tail_inc == r_tx_head) begin
                        n_tx_dropped = 1'b1;
                    end else begin
                        tx_we     = 1'b1;
                        n_tx_tail = tx_tail_inc;
                    end
                    if (r_tx_head == r_tx_tail) begin
                        n_tx_active = 1'b1;
                    end
                end
                ACT_FLUSH_RX: begin
                    n_rx_head = '0;
                    n_rx_tail = '0;
                end
                ACT_FLUSH_TX: begin
                    n_tx_head = '0;
                    n_tx_tail = '0;
                end
                ACT_LINE: begin
                    n_error_seen = (i_line_errors != '0);
                    if (i_line_rx_full) begin
                        if (rx_tail_inc == r_rx_head) begin
                            n_rx_dropped = 1'b1;
                        end else begin
                            rx_we     = 1'b1;
                            n_rx_tail = rx_tail_inc;
                        end
                    end
                    if (i_line_tx_empty) begin
                        if (r_tx_head == r_tx_tail) begin
                            n_tx_active = 1'b0;
                        end else begin
                            n_send_valid = 1'b1;
                            n_tx_head    = tx_head_inc;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // occupancy after the item
    always_comb begin
        if (n_rx_tail >= n_rx_head) begin
            rx_cnt = {1'b0, n_rx_tail} - {1'b0, n_rx_head};
        end else begin
            rx_cnt = {1'b0, n_rx_tail} + RX_CW'(RX_DEPTH) - {1'b0, n_rx_head};
        end
        if (n_tx_tail >= n_tx_head) begin
            tx_cnt = {1'b0, n_tx_tail} - {1'b0, n_tx_head};
        end else begin
            tx_cnt = {1'b0, n_tx_tail} + TX_CW'(TX_DEPTH) - {1'b0, n_tx_head};
        end
    end

    // byte stores
    always_ff @(posedge i_clk) begin
        if (rx_we) begin
            rx_mem[r_rx_tail] <= i_line_rx_byte;
        end
        r_rx_q <= rx_mem[r_rx_head];
    end

    always_ff @(posedge i_clk) begin
        if (tx_we) begin
            tx_mem[r_tx_tail] <= i_host_byte;
        end
        r_tx_q <= tx_mem[r_tx_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_head    <= '0;
            r_rx_tail    <= '0;
            r_tx_head    <= '0;
            r_tx_tail    <= '0;
            r_tx_active  <= 1'b0;
            r_done       <= 1'b0;
            r_read_valid <= 1'b0;
            r_send_valid <= 1'b0;
            r_error_seen <= 1'b0;
            r_rx_dropped <= 1'b0;
            r_tx_dropped <= 1'b0;
            r_rx_count   <= '0;
            r_tx_count   <= '0;
        end else begin
            r_rx_head    <= n_rx_head;
            r_rx_tail    <= n_rx_tail;
            r_tx_head    <= n_tx_head;
            r_tx_tail    <= n_tx_tail;
            r_tx_active  <= n_tx_active;
            r_done       <= accept;
            r_read_valid <= n_read_valid;
            r_send_valid <= n_send_valid;
            r_error_seen <= n_error_seen;
            r_rx_dropped <= n_rx_dropped;
            r_tx_dropped <= n_tx_dropped;
            r_rx_count   <= COUNT_W'(rx_cnt);
            r_tx_count   <= COUNT_W'(tx_cnt);
        end
    end

    assign o_done           = r_done;
    assign o_read_byte      = r_read_valid ? r_rx_q : '0;
    assign o_read_valid     = r_read_valid;
    assign o_send_byte      = r_send_valid ? r_tx_q : '0;
    assign o_send_valid     = r_send_valid;
    assign o_transmitter_on = r_tx_active;
    assign o_rx_count       = r_rx_count;
    assign o_tx_count       = r_tx_count;
    assign o_error_seen     = r_error_seen;
    assign o_rx_dropped     = r_rx_dropped;
    assign o_tx_dropped     = r_tx_dropped;

endmodule

FILE: rtl/urbp_checker.sv
// ----------------------------------------------------------------------------
// urbp_checker
// port-level checks for the uart ring buffer pair, bound to the top level
// ----------------------------------------------------------------------------
`include "uart_ring_buffer_pair_unit_defines.svh"

module urbp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_done,
    input logic                          o_read_valid,
    input logic                          o_send_valid,
    input logic                          o_transmitter_on,
    input logic                          o_error_seen,
    input logic                          o_tx_dropped
);
    import urbp_pkg::*;

    logic acc;
    assign acc = start && !busy;

    // one result per item, in the cycle after it is taken
    `URBP_ASSERT_NEXT(a_done_after_item, i_clk, i_rst_n, acc, o_done)
    `URBP_ASSERT_NEXT(a_no_spurious_done, i_clk, i_rst_n, !acc, !o_done)
    // a byte is only handed out while the transmitter is on
    `URBP_ASSERT_SAME(a_send_needs_tx_on, i_clk, i_rst_n, o_send_valid, o_transmitter_on)
    // a pop result carries no line or push flags
    `URBP_ASSERT_SAME(a_pop_exclusive, i_clk, i_rst_n, o_read_valid,
        o_done && !o_error_seen && !o_tx_dropped && !o_send_valid)

endmodule

bind uart_ring_buffer_pair_unit urbp_checker u_urbp_checker (.*);
